// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/rtb_pkg.sv -----
// Types and constants for the reload timer bank.
package rtb_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CNT_W        = 32;
    localparam int CH_W         = 4;
    localparam int ALLOC_W      = 5;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_ENABLE  = 3'd1,
        OP_DISABLE = 3'd2,
        OP_UPDATE  = 3'd3,
        OP_TICK    = 3'd4
    } rtb_op_t;

    // Command that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic [2:0]              op;
        logic [CH_W-1:0]         channel;
        logic [CNT_W-1:0]        count_value;
        logic                    alloc_load;
        logic                    alloc_ok;
        logic [CH_W-1:0]         alloc_idx;
        logic [MAX_CHANNELS-1:0] mask;
    } rtb_token_t;

endpackage

// ----- hw/rtl/rtb_cell.sv -----
// One timer channel: counter, reload value and enable, applying the passing command.
module rtb_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_in_valid,
    input  rtb_pkg::rtb_token_t tok_in,
    output logic                tok_out_valid,
    output rtb_pkg::rtb_token_t tok_out
);

    logic [rtb_pkg::CNT_W-1:0] counter_reg, counter_next;
    logic [rtb_pkg::CNT_W-1:0] reload_reg, reload_next;
    logic                      enable_reg, enable_next;
    logic                      tok_valid_reg;
    rtb_pkg::rtb_token_t       tok_reg, tok_next;
    logic [rtb_pkg::CNT_W-1:0] dec;
    logic                      hit_ch;

    assign dec    = counter_reg - rtb_pkg::CNT_W'(1);
    assign hit_ch = (tok_in.channel == rtb_pkg::CH_W'(IDX));

    always_comb
    begin
        counter_next = counter_reg;
        reload_next  = reload_reg;
        enable_next  = enable_reg;
        tok_next     = tok_in;
        if (tok_in_valid)
        begin
            case (tok_in.op)
                rtb_pkg::OP_ALLOC:
                begin
                    if (tok_in.alloc_load && (tok_in.alloc_idx == rtb_pkg::CH_W'(IDX)))
                    begin
                        counter_next = tok_in.count_value;
                        reload_next  = tok_in.count_value;
                    end
                end
                rtb_pkg::OP_ENABLE:
                begin
                    if (hit_ch)
                        enable_next = 1'b1;
                end
                rtb_pkg::OP_DISABLE:
                begin
                    if (hit_ch)
                        enable_next = 1'b0;
                end
                rtb_pkg::OP_UPDATE:
                begin
                    if (hit_ch)
                    begin
                        counter_next = tok_in.count_value;
                        reload_next  = tok_in.count_value;
                    end
                end
                rtb_pkg::OP_TICK:
                begin
                    if (enable_reg)
                    begin
                        if (dec == '0)
                        begin
                            // expire: restore the period and flag this channel
                            counter_next = reload_reg;
                            tok_next.mask = tok_in.mask
                                | (rtb_pkg::MAX_CHANNELS'(1) << IDX);
                        end
                        else
                            counter_next = dec;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            reload_reg    <= '0;
            enable_reg    <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            counter_reg   <= counter_next;
            reload_reg    <= reload_next;
            enable_reg    <= enable_next;
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_out_valid = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ----- hw/rtl/reload_timer_bank_core.sv -----
// Top level of the reload timer bank: request intake, cell chain and result register.
//
//  channel | signals                                            | accepted when
//  --------+----------------------------------------------------+--------------------------
//  req     | req_valid, req_ready, op, channel, count_value,    | req_valid && req_ready
//          | handler_present                                    |
//  rsp     | rsp_valid, rsp_ready, alloc_ok, alloc_channel,     | rsp_valid && rsp_ready
//          | expired_mask                                       |
//
// An item walks the chain of CHANNELS cells, one cell per cycle, then res_reg, and then
// the output register that drives rsp_valid; the chain holds one item at a time.
// A new item is taken once the previous result has moved into the output register,
// so the next item waits while one is in the chain or in res_reg; a stalled rsp holds that move.
// Reset clears all counters, reload values, enables and the allocation count.
module reload_timer_bank_core #(
    parameter int CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  op,
    input  logic [3:0]  channel,
    input  logic [31:0] count_value,
    input  logic        handler_present,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        alloc_ok,
    output logic [3:0]  alloc_channel,
    output logic [15:0] expired_mask
);

    `include "assert_macros.svh"

    localparam logic [rtb_pkg::ALLOC_W-1:0] CH_LIMIT = rtb_pkg::ALLOC_W'(CHANNELS);

    logic                            tok_valid [CHANNELS+1];
    rtb_pkg::rtb_token_t             tok       [CHANNELS+1];
    rtb_pkg::rtb_token_t             head_tok;
    logic [CHANNELS-1:0]             chain_busy;
    logic [rtb_pkg::ALLOC_W-1:0]     alloc_cnt_reg, alloc_cnt_next;
    logic                            res_valid_reg, res_valid_next;
    rtb_pkg::rtb_token_t             res_reg;
    logic                            out_valid_reg, out_valid_next;
    logic                            out_ok_reg;
    logic [rtb_pkg::CH_W-1:0]        out_ch_reg;
    logic [rtb_pkg::MAX_CHANNELS-1:0] out_mask_reg;
    logic                            accept;
    logic                            has_free;
    logic                            out_load;

    assign has_free = (alloc_cnt_reg < CH_LIMIT);
    assign accept   = req_valid && req_ready;
    assign req_ready = !(|chain_busy) && !res_valid_reg;

    // build the command for the head of the chain
    always_comb
    begin
        head_tok.op          = op;
        head_tok.channel     = channel;
        head_tok.count_value = count_value;
        head_tok.alloc_load  = (op == rtb_pkg::OP_ALLOC) && has_free;
        head_tok.alloc_ok    = (op == rtb_pkg::OP_ALLOC) && has_free && handler_present;
        head_tok.alloc_idx   = alloc_cnt_reg[rtb_pkg::CH_W-1:0];
        head_tok.mask        = '0;
    end
    assign tok[0]       = head_tok;
    assign tok_valid[0] = accept;

    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++)
        begin : g_cell
            rtb_cell #(.IDX(gi)) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .tok_in_valid  (tok_valid[gi]),
                .tok_in        (tok[gi]),
                .tok_out_valid (tok_valid[gi+1]),
                .tok_out       (tok[gi+1])
            );
            assign chain_busy[gi] = tok_valid[gi+1];
        end
    endgenerate

    assign out_load = res_valid_reg && (!out_valid_reg || rsp_ready);

    always_comb
    begin
        alloc_cnt_next = alloc_cnt_reg;
        if (accept && head_tok.alloc_ok)
            alloc_cnt_next = alloc_cnt_reg + rtb_pkg::ALLOC_W'(1);

        res_valid_next = res_valid_reg;
        if (tok_valid[CHANNELS])
            res_valid_next = 1'b1;
        else if (out_load)
            res_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_cnt_reg <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            alloc_cnt_reg <= alloc_cnt_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid[CHANNELS])
            res_reg <= tok[CHANNELS];
        if (out_load)
        begin
            out_ok_reg   <= res_reg.alloc_ok;
            out_ch_reg   <= res_reg.alloc_ok ? res_reg.alloc_idx : '0;
            out_mask_reg <= res_reg.mask;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign alloc_ok      = out_ok_reg;
    assign alloc_channel = out_ch_reg;
    assign expired_mask  = out_mask_reg;

    `ASSERT_CLK(a_one_item_in_chain, $onehot0(chain_busy), "more than one item in cell chain")
    `ASSERT_CLK(a_busy_after_accept, accept |=> !req_ready, "item accepted while chain busy")
    `ASSERT_NEVER(a_alloc_limit, alloc_cnt_reg > CH_LIMIT, "allocation count past channel count")

endmodule

// ----- tb/sv/rtb_score_pkg.sv -----
// Scoreboard for the reload timer bank: timer state copy and result queue.
package rtb_score_pkg;

    import rtb_pkg::*;

    typedef struct packed {
        logic                    ok;
        logic [CH_W-1:0]         channel;
        logic [MAX_CHANNELS-1:0] mask;
    } timer_result_t;

    class expiry_scoreboard;

        logic [CNT_W-1:0]        counters [MAX_CHANNELS];
        logic [CNT_W-1:0]        reloads  [MAX_CHANNELS];
        logic [MAX_CHANNELS-1:0] enables;
        logic [ALLOC_W-1:0]      claimed;
        timer_result_t           expected_q [$];
        int                      failures;

        function new();
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                counters[i] = '0;
                reloads[i]  = '0;
            end
            enables  = '0;
            claimed  = '0;
            failures = 0;
        endfunction

        // Advance the timer state by one accepted item and queue its result.
        function void note_item(logic [2:0] code, logic [CH_W-1:0] ch,
                                logic [CNT_W-1:0] cnt, logic hp);
            timer_result_t res;
            logic [CH_W-1:0] slot;
            res  = '0;
            slot = claimed[CH_W-1:0];
            case (code)
                OP_ALLOC:
                    if (claimed < MAX_CHANNELS)
                    begin
                        // the slot is loaded even when the claim fails
                        counters[slot] = cnt;
                        reloads[slot]  = cnt;
                        if (hp)
                        begin
                            res.ok      = 1'b1;
                            res.channel = slot;
                            claimed     = claimed + 1'b1;
                        end
                    end
                OP_ENABLE:  enables[ch] = 1'b1;
                OP_DISABLE: enables[ch] = 1'b0;
                OP_UPDATE:
                begin
                    counters[ch] = cnt;
                    reloads[ch]  = cnt;
                end
                OP_TICK:
                    for (int i = 0; i < MAX_CHANNELS; i++)
                    begin
                        if (enables[i])
                        begin
                            counters[i] = counters[i] - 1'b1;
                            if (counters[i] == '0)
                            begin
                                res.mask[i] = 1'b1;
                                counters[i] = reloads[i];
                            end
                        end
                    end
                default: ;
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic ok, logic [CH_W-1:0] ch,
                                   logic [MAX_CHANNELS-1:0] mask);
            timer_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: ok=%0d channel=%0d mask=%04h",
                             ok, ch, mask);
                return;
            end
            exp_res = expected_q.pop_front();
            if (ok !== exp_res.ok || ch !== exp_res.channel || mask !== exp_res.mask)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected ok=%0d channel=%0d mask=%04h, got ok=%0d channel=%0d mask=%04h",
                             exp_res.ok, exp_res.channel, exp_res.mask, ok, ch, mask);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

// ----- tb/sv/tb.sv -----
// Top-level testbench for reload_timer_bank_core: stimulus, handshakes and checking.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtb_pkg::*;
    import rtb_score_pkg::*;

    localparam logic [2:0]      OP_UNUSED_LO    = 3'd5;
    localparam logic [2:0]      OP_UNUSED_HI    = 3'd7;
    localparam logic [CH_W-1:0] LAST_CH         = CH_W'(MAX_CHANNELS - 1);
    localparam int              CHAIN_LATENCY   = MAX_CHANNELS + 2;
    localparam int              PRESSURE_CYCLES = 400;
    localparam int              STALL_LIMIT     = 3000;
    localparam int              PHASE_ITEMS     = 530;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [2:0]  op = '0;
    logic [3:0]  channel = '0;
    logic [31:0] count_value = '0;
    logic        handler_present = 1'b0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic        alloc_ok;
    logic [3:0]  alloc_channel;
    logic [15:0] expired_mask;

    int send_idle_pct = 28;
    int recv_idle_pct = 58;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    expiry_scoreboard sb = new();

    reload_timer_bank_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .op              (op),
        .channel         (channel),
        .count_value     (count_value),
        .handler_present (handler_present),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .alloc_ok        (alloc_ok),
        .alloc_channel   (alloc_channel),
        .expired_mask    (expired_mask)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off to fill the block.
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_left = PRESSURE_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe both handshakes and run the checks.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_item(op, channel, count_value, handler_present);
            if (rsp_valid && rsp_ready)
                sb.check_result(alloc_ok, alloc_channel, expired_mask);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [2:0] code, input logic [3:0] ch,
                             input logic [31:0] cnt, input logic hp);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid       <= 1'b1;
        op              <= code;
        channel         <= ch;
        count_value     <= cnt;
        handler_present <= hp;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Ticks more often than any other command, mostly against small periods so channels expire often.
    task automatic send_random();
        int          pick;
        int          r;
        logic [2:0]  code;
        logic [31:0] cnt;
        pick = $urandom_range(99);
        r    = $urandom_range(99);
        if (pick < 45)
            code = OP_TICK;
        else if (pick < 60)
            code = OP_ENABLE;
        else if (pick < 67)
            code = OP_DISABLE;
        else if (pick < 82)
            code = OP_UPDATE;
        else if (pick < 95)
            code = OP_ALLOC;
        else
            code = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        if (r < 60)
            cnt = $urandom_range(12);
        else if (r < 70)
            cnt = ($urandom_range(1) != 0) ? '1 : '0;
        else
            cnt = $urandom();
        send_item(code, 4'($urandom_range(LAST_CH)), cnt, ($urandom_range(99) < 75));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        // enabled but never allocated: zero counter wraps without expiry
        send_item(OP_ENABLE, LAST_CH, 32'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_item(OP_UPDATE, LAST_CH, 32'd1, 1'b0);
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_item(OP_UPDATE, LAST_CH, 32'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        // allocate without handler loads the slot but does not claim it
        send_item(OP_ALLOC, 4'd0, 32'd3, 1'b0);
        send_item(OP_ALLOC, LAST_CH, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_ALLOC, 4'd0, 32'd2, 1'b1);
        send_item(OP_ENABLE, 4'd0, 32'd0, 1'b0);
        send_item(OP_ENABLE, 4'd1, 32'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_item(OP_DISABLE, LAST_CH, 32'd0, 1'b0);
        send_item(OP_DISABLE, 4'd0, 32'd0, 1'b0);
        send_item(OP_TICK, 4'd0, 32'd0, 1'b0);
        for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
            send_item(3'(c), LAST_CH, $urandom(), 1'b1);
        send_item(OP_UPDATE, 4'd1, 32'h8000_0000, 1'b1);

        repeat (PHASE_ITEMS) send_random();
        send_idle_pct = 58;
        recv_idle_pct = 28;
        repeat (PHASE_ITEMS) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (PHASE_ITEMS + 10) send_random();
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4 * CHAIN_LATENCY) @(posedge clk);
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
